[design/crc_pkg.sv]
// crc_pkg: shared widths, register indexes and types for the catmull-rom curve point block
// no dependencies; imported by crc_curve, crc_norm, catmull_rom_curve_point_top and tb
package crc_pkg;

  localparam int COORD_BITS      = 20;
  localparam int PARAM_FRAC_BITS = 16;
  localparam int DELTA_STEP      = 66;
  localparam int PARAM_BITS      = 24;
  localparam int DIR_BITS        = 16;
  localparam int CFG_BITS        = 60;
  localparam int CFG_IDX_BITS    = 3;

  localparam logic [CFG_IDX_BITS-1:0] CFG_POINT_A   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_POINT_B   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_POINT_C   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_POINT_D   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SHIFT     = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LOOP_MODE = 3'd5;

  localparam int AXES      = 3;
  localparam int NPTS      = 4;
  localparam int ROW_BITS  = AXES * COORD_BITS;
  localparam int PEXT_BITS = PARAM_BITS + 1;
  localparam int T_BITS    = PARAM_FRAC_BITS + 1;
  localparam int W_BITS    = PARAM_FRAC_BITS + 4;
  localparam int PROD_BITS = W_BITS + COORD_BITS;
  localparam int SUM_BITS  = PROD_BITS + 2;
  localparam int POS_BITS  = COORD_BITS + 4;
  localparam int DIFF_BITS = POS_BITS + 1;
  localparam int MAG_BITS  = DIFF_BITS;
  localparam int SQ_BITS   = 2 * MAG_BITS;
  localparam int LEN_BITS  = SQ_BITS + 2;
  localparam int LEN_SHIFT = 14;
  localparam int ROOT_BITS = (LEN_BITS + LEN_SHIFT + 1) / 2;
  localparam int RAD_BITS  = 2 * ROOT_BITS;
  localparam int REM_BITS  = ROOT_BITS + 3;
  localparam int DIR_SHIFT = 21;
  localparam int Q_BITS    = DIR_BITS - 1;
  localparam int DIVW      = ROOT_BITS + Q_BITS;

  localparam logic [Q_BITS-1:0] DIR_MAX = Q_BITS'(64'd1 << (DIR_BITS - 2));

  localparam int CURVE_LAT = 5;
  localparam int NORM_LAT  = ROOT_BITS + Q_BITS + 4;
  localparam int PIPE_LAT  = CURVE_LAT + 1 + NORM_LAT;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [POS_BITS-1:0]   pos_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [DIR_BITS-1:0]   dir_t;

  typedef struct packed {
    logic                           loop_mode;
    logic [NPTS-1:0][ROW_BITS-1:0]  pts;
    logic [ROW_BITS-1:0]            shift;
  } curve_cfg_t;

  function automatic coord_t coord_of(input logic [ROW_BITS-1:0] row, input int unsigned axis);
    return coord_t'(row[axis*COORD_BITS +: COORD_BITS]);
  endfunction

endpackage

[design/crc_curve.sv]
// crc_curve: five-stage pipelined catmull-rom evaluator for one parameter
// depends on crc_pkg
module crc_curve (
  input  logic                                 clk,
  input  logic                                 en,
  input  crc_pkg::curve_cfg_t                  cfg,
  input  logic signed [crc_pkg::PEXT_BITS-1:0] p,
  output crc_pkg::pos_t                        pos [crc_pkg::AXES]
);
  import crc_pkg::*;

  localparam logic signed [PEXT_BITS-1:0] ONE_P   = PEXT_BITS'(64'd1 << PARAM_FRAC_BITS);
  localparam logic signed [W_BITS-1:0]    TWO_ONE = W_BITS'(64'd2 << PARAM_FRAC_BITS);
  localparam logic signed [SUM_BITS-1:0]  ONE_S   = SUM_BITS'(64'd1 << PARAM_FRAC_BITS);

  logic [1:0]                    base;
  logic [T_BITS-1:0]             t_nxt;
  logic [NPTS-1:0][ROW_BITS-1:0] rot_nxt;

  logic [T_BITS-1:0]             t_r1, t_r2, t2_r2;
  logic [2*T_BITS-1:0]           sq_r1, cube_r2;
  logic [NPTS-1:0][ROW_BITS-1:0] rot_r1, rot_r2, rot_r3;
  logic signed [W_BITS-1:0]      w_nxt [NPTS];
  logic signed [W_BITS-1:0]      w_r3  [NPTS];
  logic signed [PROD_BITS-1:0]   prod_nxt [AXES][NPTS];
  logic signed [PROD_BITS-1:0]   prod_r4  [AXES][NPTS];
  pos_t                          pos_nxt [AXES];
  pos_t                          pos_r5  [AXES];

  logic [T_BITS-1:0]        t2_c, t3_c;
  logic signed [W_BITS-1:0] ts, t2s, t3s;
  logic signed [SUM_BITS-1:0] acc;

  // segment select and clamp
  always_comb begin
    base  = 2'b00;
    t_nxt = '0;
    if (cfg.loop_mode) begin
      base  = p[PARAM_FRAC_BITS +: 2];
      t_nxt = {1'b0, p[PARAM_FRAC_BITS-1:0]};
    end else if (p < 0) begin
      t_nxt = '0;
    end else if (p > ONE_P) begin
      t_nxt = ONE_P[T_BITS-1:0];
    end else begin
      t_nxt = p[T_BITS-1:0];
    end
    for (int k = 0; k < NPTS; k++) begin
      rot_nxt[k] = cfg.pts[2'(base + 2'(k))];
    end
  end

  // basis weights and weight-coordinate products
  always_comb begin
    t2_c = sq_r1[PARAM_FRAC_BITS +: T_BITS];
    t3_c = cube_r2[PARAM_FRAC_BITS +: T_BITS];
    ts   = W_BITS'(t_r2);
    t2s  = W_BITS'(t2_r2);
    t3s  = W_BITS'(t3_c);
    w_nxt[0] = (t2s <<< 1) - t3s - ts;
    w_nxt[1] = t3s + (t3s <<< 1) - (t2s <<< 2) - t2s + TWO_ONE;
    w_nxt[2] = (t2s <<< 2) + ts - t3s - (t3s <<< 1);
    w_nxt[3] = t3s - t2s;
    for (int a = 0; a < AXES; a++) begin
      for (int k = 0; k < NPTS; k++) begin
        prod_nxt[a][k] = PROD_BITS'(w_r3[k] * coord_of(rot_r3[k], a));
      end
    end
  end

  // weighted sum, round half up, add offset
  always_comb begin
    acc = '0;
    for (int a = 0; a < AXES; a++) begin
      acc = ONE_S;
      for (int k = 0; k < NPTS; k++) begin
        acc = acc + SUM_BITS'(prod_r4[a][k]);
      end
      pos_nxt[a] = POS_BITS'(acc >>> (PARAM_FRAC_BITS + 1))
                 + POS_BITS'(coord_of(cfg.shift, a));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r1    <= t_nxt;
      rot_r1  <= rot_nxt;
      sq_r1   <= t_nxt * t_nxt;
      t_r2    <= t_r1;
      t2_r2   <= t2_c;
      cube_r2 <= t2_c * t_r1;
      rot_r2  <= rot_r1;
      w_r3    <= w_nxt;
      rot_r3  <= rot_r2;
      prod_r4 <= prod_nxt;
      pos_r5  <= pos_nxt;
    end
  end

  assign pos = pos_r5;

endmodule

[design/crc_norm.sv]
// crc_norm: pipelined tangent normalizer (square sum, bit-serial root, restoring divide)
// depends on crc_pkg
module crc_norm (
  input  logic          clk,
  input  logic          en,
  input  crc_pkg::diff_t d   [crc_pkg::AXES],
  output crc_pkg::dir_t  dir [crc_pkg::AXES]
);
  import crc_pkg::*;

  // square stage
  logic [MAG_BITS-1:0] mag_nxt [AXES];
  logic [MAG_BITS-1:0] mag_r1  [AXES];
  logic [SQ_BITS-1:0]  sq_r1   [AXES];
  logic [AXES-1:0]     neg_r1;
  logic [LEN_BITS-1:0] len_c;

  // root stages, index 0 holds the radicand
  logic [RAD_BITS-1:0]  sx_r    [ROOT_BITS+1];
  logic [REM_BITS-1:0]  srem_r  [ROOT_BITS+1];
  logic [ROOT_BITS-1:0] sroot_r [ROOT_BITS+1];
  logic [MAG_BITS-1:0]  smag_r  [ROOT_BITS+1][AXES];
  logic [AXES-1:0]      sneg_r  [ROOT_BITS+1];
  logic                 szero_r [ROOT_BITS+1];
  logic [RAD_BITS-1:0]  sx_nxt    [ROOT_BITS+1];
  logic [REM_BITS-1:0]  srem_nxt  [ROOT_BITS+1];
  logic [ROOT_BITS-1:0] sroot_nxt [ROOT_BITS+1];

  // divide stages, index 0 holds the numerators
  logic [DIVW-1:0]      drem_r  [Q_BITS+1][AXES];
  logic [Q_BITS-1:0]    dq_r    [Q_BITS+1][AXES];
  logic [ROOT_BITS-1:0] dl_r    [Q_BITS+1];
  logic [AXES-1:0]      dneg_r  [Q_BITS+1];
  logic                 dzero_r [Q_BITS+1];
  logic [DIVW-1:0]      drem_nxt [Q_BITS+1][AXES];
  logic [Q_BITS-1:0]    dq_nxt   [Q_BITS+1][AXES];

  dir_t dir_nxt [AXES];
  dir_t dir_r   [AXES];

  logic [REM_BITS-1:0] cur, trial;
  logic [DIVW-1:0]     dsh;
  logic [Q_BITS-1:0]   qq;

  always_comb begin
    len_c = '0;
    for (int a = 0; a < AXES; a++) begin
      mag_nxt[a] = d[a][DIFF_BITS-1] ? MAG_BITS'(-d[a]) : MAG_BITS'(d[a]);
      len_c      = len_c + LEN_BITS'(sq_r1[a]);
    end
  end

  // one root bit per stage
  always_comb begin
    cur   = '0;
    trial = '0;
    sx_nxt[0]    = RAD_BITS'(len_c) << LEN_SHIFT;
    srem_nxt[0]  = '0;
    sroot_nxt[0] = '0;
    for (int j = 1; j <= ROOT_BITS; j++) begin
      cur   = {srem_r[j-1][REM_BITS-3:0], sx_r[j-1][RAD_BITS-1 -: 2]};
      trial = {1'b0, sroot_r[j-1], 2'b01};
      sx_nxt[j] = sx_r[j-1] << 2;
      if (cur >= trial) begin
        srem_nxt[j]  = cur - trial;
        sroot_nxt[j] = {sroot_r[j-1][ROOT_BITS-2:0], 1'b1};
      end else begin
        srem_nxt[j]  = cur;
        sroot_nxt[j] = {sroot_r[j-1][ROOT_BITS-2:0], 1'b0};
      end
    end
  end

  // one quotient bit per stage
  always_comb begin
    dsh = '0;
    for (int a = 0; a < AXES; a++) begin
      drem_nxt[0][a] = (DIVW'(smag_r[ROOT_BITS][a]) << DIR_SHIFT)
                     + DIVW'(sroot_r[ROOT_BITS] >> 1);
      dq_nxt[0][a]   = '0;
    end
    for (int k = 1; k <= Q_BITS; k++) begin
      dsh = DIVW'(dl_r[k-1]) << (Q_BITS - k);
      for (int a = 0; a < AXES; a++) begin
        dq_nxt[k][a] = dq_r[k-1][a];
        if (drem_r[k-1][a] >= dsh) begin
          drem_nxt[k][a]              = drem_r[k-1][a] - dsh;
          dq_nxt[k][a][Q_BITS - k]    = 1'b1;
        end else begin
          drem_nxt[k][a] = drem_r[k-1][a];
        end
      end
    end
  end

  always_comb begin
    qq = '0;
    for (int a = 0; a < AXES; a++) begin
      qq = (dq_r[Q_BITS][a] > DIR_MAX) ? DIR_MAX : dq_r[Q_BITS][a];
      if (dzero_r[Q_BITS]) begin
        dir_nxt[a] = '0;
      end else if (dneg_r[Q_BITS][a]) begin
        dir_nxt[a] = -DIR_BITS'(qq);
      end else begin
        dir_nxt[a] = DIR_BITS'(qq);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < AXES; a++) begin
        mag_r1[a]    <= mag_nxt[a];
        sq_r1[a]     <= mag_nxt[a] * mag_nxt[a];
        neg_r1[a]    <= d[a][DIFF_BITS-1];
        smag_r[0][a] <= mag_r1[a];
      end
      sneg_r[0]  <= neg_r1;
      szero_r[0] <= (len_c == '0);
      sx_r       <= sx_nxt;
      srem_r     <= srem_nxt;
      sroot_r    <= sroot_nxt;
      for (int j = 1; j <= ROOT_BITS; j++) begin
        smag_r[j]  <= smag_r[j-1];
        sneg_r[j]  <= sneg_r[j-1];
        szero_r[j] <= szero_r[j-1];
      end
      drem_r     <= drem_nxt;
      dq_r       <= dq_nxt;
      dl_r[0]    <= sroot_r[ROOT_BITS];
      dneg_r[0]  <= sneg_r[ROOT_BITS];
      dzero_r[0] <= szero_r[ROOT_BITS];
      for (int k = 1; k <= Q_BITS; k++) begin
        dl_r[k]    <= dl_r[k-1];
        dneg_r[k]  <= dneg_r[k-1];
        dzero_r[k] <= dzero_r[k-1];
      end
      dir_r <= dir_nxt;
    end
  end

  assign dir = dir_r;

endmodule

[design/catmull_rom_curve_point_top.sv]
// catmull_rom_curve_point_top: top level of the catmull-rom curve point block
// depends on crc_pkg, crc_curve and crc_norm
//
// usage
//   configuration: write point_a..point_d, shift (packed x,y,z Q12.8) and loop_mode
//   through cfg_wr_en / cfg_index / cfg_data while the block is idle; writes to
//   indexes beyond loop_mode are dropped
//   input channel: one curve parameter (signed Q8.16) per transfer on in_valid/in_stall
//   result channel: one transfer per input, position (saturated Q12.8) and unit
//   tangent (Q1.14) on out_valid/out_stall
//   throughput: one item per cycle unless a result is held by out_stall; fully pipelined
//   depth: 5 stages per curve evaluation, one difference stage, then the normalizer
//   whose depth is set by the bit-serial square root (one root bit per stage) and
//   divider (one quotient bit per stage)
//   reset: valid bits and configuration registers clear, datapath registers do not
//   stall: a held result freezes the whole pipeline; in_stall rises only while a
//   result waits on out_stall, so bubbles never block new input
module catmull_rom_curve_point_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [crc_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [crc_pkg::CFG_BITS-1:0]          cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [crc_pkg::PARAM_BITS-1:0] in_param,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output crc_pkg::coord_t                       out_pos_x,
  output crc_pkg::coord_t                       out_pos_y,
  output crc_pkg::coord_t                       out_pos_z,
  output crc_pkg::dir_t                         out_dir_x,
  output crc_pkg::dir_t                         out_dir_y,
  output crc_pkg::dir_t                         out_dir_z
);
  import crc_pkg::*;

  localparam pos_t SAT_HI = POS_BITS'((64'd1 << (COORD_BITS - 1)) - 64'd1);
  localparam pos_t SAT_LO = -SAT_HI - POS_BITS'(1);

  // configuration registers
  logic [ROW_BITS-1:0] pt_a_r, pt_b_r, pt_c_r, pt_d_r, shift_r;
  logic                loop_mode_r;
  curve_cfg_t          ccfg;

  // pipeline control
  logic                en;
  logic [PIPE_LAT-1:0] vld_r;

  logic signed [PEXT_BITS-1:0] p_a, p_b;
  pos_t   pos_a [AXES];
  pos_t   pos_b [AXES];
  diff_t  d_nxt [AXES];
  diff_t  d_r6  [AXES];
  coord_t sat_nxt [AXES];
  coord_t sat_r6  [AXES];
  coord_t pos_dly_r [NORM_LAT][AXES];
  dir_t   dir [AXES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_a_r      <= '0;
      pt_b_r      <= '0;
      pt_c_r      <= '0;
      pt_d_r      <= '0;
      shift_r     <= '0;
      loop_mode_r <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_POINT_A:   pt_a_r      <= cfg_data[ROW_BITS-1:0];
        CFG_POINT_B:   pt_b_r      <= cfg_data[ROW_BITS-1:0];
        CFG_POINT_C:   pt_c_r      <= cfg_data[ROW_BITS-1:0];
        CFG_POINT_D:   pt_d_r      <= cfg_data[ROW_BITS-1:0];
        CFG_SHIFT:     shift_r     <= cfg_data[ROW_BITS-1:0];
        CFG_LOOP_MODE: loop_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign ccfg.loop_mode = loop_mode_r;
  assign ccfg.pts       = {pt_d_r, pt_c_r, pt_b_r, pt_a_r};
  assign ccfg.shift     = shift_r;

  // everything moves unless a finished result is being held
  assign en       = !vld_r[PIPE_LAT-1] || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_LAT-2:0], in_valid};
    end
  end

  // second evaluation point, no wrap of the parameter
  assign p_a = {in_param[PARAM_BITS-1], in_param};
  assign p_b = p_a + PEXT_BITS'(DELTA_STEP);

  crc_curve u_curve_a (
    .clk (clk),
    .en  (en),
    .cfg (ccfg),
    .p   (p_a),
    .pos (pos_a)
  );

  crc_curve u_curve_b (
    .clk (clk),
    .en  (en),
    .cfg (ccfg),
    .p   (p_b),
    .pos (pos_b)
  );

  // tangent difference on unsaturated positions, saturate the output position
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      d_nxt[a] = DIFF_BITS'(pos_b[a]) - DIFF_BITS'(pos_a[a]);
      if (pos_a[a] > SAT_HI) begin
        sat_nxt[a] = COORD_BITS'(SAT_HI);
      end else if (pos_a[a] < SAT_LO) begin
        sat_nxt[a] = COORD_BITS'(SAT_LO);
      end else begin
        sat_nxt[a] = COORD_BITS'(pos_a[a]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r6         <= d_nxt;
      sat_r6       <= sat_nxt;
      pos_dly_r[0] <= sat_r6;
      for (int s = 1; s < NORM_LAT; s++) begin
        pos_dly_r[s] <= pos_dly_r[s-1];
      end
    end
  end

  crc_norm u_norm (
    .clk (clk),
    .en  (en),
    .d   (d_r6),
    .dir (dir)
  );

  assign out_valid = vld_r[PIPE_LAT-1];
  assign out_pos_x = pos_dly_r[NORM_LAT-1][0];
  assign out_pos_y = pos_dly_r[NORM_LAT-1][1];
  assign out_pos_z = pos_dly_r[NORM_LAT-1][2];
  assign out_dir_x = dir[0];
  assign out_dir_y = dir[1];
  assign out_dir_z = dir[2];

endmodule

[dv/tb.sv]
// tb: self-checking testbench for catmull_rom_curve_point_top
// depends on crc_pkg and the block's rtl; holds its own fixed-point curve predictor
`timescale 1ns / 1ps

module tb;
  import crc_pkg::*;

  // one result transfer as the predictor sees it
  typedef struct {
    logic [19:0] px, py, pz;
    logic [15:0] dx, dy, dz;
    logic signed [23:0] param;
  } curve_point_t;

  // scoreboard: predicts position and tangent for each accepted parameter
  class curve_scoreboard;
    logic [59:0] pts[4];
    logic [59:0] offs;
    bit wrap;
    curve_point_t pending[$];
    int mismatches;
    int checked;

    function new();
      foreach (pts[k]) pts[k] = '0;
      offs = '0;
      wrap = 0;
      mismatches = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [59:0] val);
      case (idx)
        CFG_POINT_A:   pts[0] = val;
        CFG_POINT_B:   pts[1] = val;
        CFG_POINT_C:   pts[2] = val;
        CFG_POINT_D:   pts[3] = val;
        CFG_SHIFT:     offs = val;
        CFG_LOOP_MODE: wrap = val[0];
        default: ;
      endcase
    endfunction

    function longint axis_of(logic [59:0] row, int a);
      logic signed [19:0] c;
      c = row[a*20 +: 20];
      return longint'(c);
    endfunction

    function longint root_floor(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // unsaturated curve position at a full-width parameter
    function void eval_at(longint p, output longint res[3]);
      longint one, t, t2, t3;
      longint w[4];
      longint s;
      int base;
      one = 64'sd1 <<< PARAM_FRAC_BITS;
      base = 0;
      if (wrap) begin
        base = int'((p >>> PARAM_FRAC_BITS) & 3);
        t = p & (one - 1);
      end else begin
        t = (p < 0) ? 0 : ((p > one) ? one : p);
      end
      t2 = (t * t) >>> PARAM_FRAC_BITS;
      t3 = (t2 * t) >>> PARAM_FRAC_BITS;
      w[0] = -t3 + 2 * t2 - t;
      w[1] = 3 * t3 - 5 * t2 + 2 * one;
      w[2] = -3 * t3 + 4 * t2 + t;
      w[3] = t3 - t2;
      for (int a = 0; a < 3; a++) begin
        s = 0;
        for (int k = 0; k < 4; k++) s += w[k] * axis_of(pts[(base + k) & 3], a);
        res[a] = ((s + one) >>> (PARAM_FRAC_BITS + 1)) + axis_of(offs, a);
      end
    endfunction

    function void note_param(logic signed [23:0] prm);
      longint here[3], ahead[3], d[3];
      longint unsigned len2, root, mag, q;
      longint v;
      curve_point_t e;
      eval_at(longint'(prm), here);
      eval_at(longint'(prm) + DELTA_STEP, ahead);
      len2 = 0;
      for (int a = 0; a < 3; a++) begin
        d[a] = ahead[a] - here[a];
        len2 += longint'(d[a] * d[a]);
      end
      e.param = prm;
      v = (here[0] > 524287) ? 524287 : ((here[0] < -524288) ? -524288 : here[0]);
      e.px = v[19:0];
      v = (here[1] > 524287) ? 524287 : ((here[1] < -524288) ? -524288 : here[1]);
      e.py = v[19:0];
      v = (here[2] > 524287) ? 524287 : ((here[2] < -524288) ? -524288 : here[2]);
      e.pz = v[19:0];
      e.dx = 0; e.dy = 0; e.dz = 0;
      if (len2 != 0) begin
        root = root_floor(len2 << 14);
        for (int a = 0; a < 3; a++) begin
          mag = (d[a] < 0) ? -d[a] : d[a];
          q = ((mag << 21) + root / 2) / root;
          if (q > 16384) q = 16384;
          v = (d[a] < 0) ? -longint'(q) : longint'(q);
          if (a == 0) e.dx = v[15:0];
          else if (a == 1) e.dy = v[15:0];
          else e.dz = v[15:0];
        end
      end
      pending.push_back(e);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("mismatch %s: got %h want %h", what, got, want);
    endtask

    task check_result(logic [19:0] px, logic [19:0] py, logic [19:0] pz,
                      logic [15:0] dx, logic [15:0] dy, logic [15:0] dz);
      curve_point_t e;
      if (pending.size() == 0) begin
        report("unexpected transfer", 0, 0);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (px !== e.px) report($sformatf("pos_x p=%h", e.param), px, e.px);
      if (py !== e.py) report($sformatf("pos_y p=%h", e.param), py, e.py);
      if (pz !== e.pz) report($sformatf("pos_z p=%h", e.param), pz, e.pz);
      if (dx !== e.dx) report($sformatf("dir_x p=%h", e.param), dx, e.dx);
      if (dy !== e.dy) report($sformatf("dir_y p=%h", e.param), dy, e.dy);
      if (dz !== e.dz) report($sformatf("dir_z p=%h", e.param), dz, e.dz);
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_wr_en = 0;
  logic [2:0] cfg_index = '0;
  logic [59:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [23:0] in_param = '0;
  logic out_valid;
  logic out_stall = 0;
  coord_t out_pos_x, out_pos_y, out_pos_z;
  dir_t out_dir_x, out_dir_y, out_dir_z;

  curve_scoreboard sb = new();
  int cycles = 0;
  int sent = 0;
  int phases_run = 0;
  bit stall_quiet = 0;

  always #2 clk = ~clk;

  catmull_rom_curve_point_top DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_param(in_param),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z),
    .out_dir_x(out_dir_x), .out_dir_y(out_dir_y), .out_dir_z(out_dir_z)
  );

  // monitor: transfers counted on the rising edge, pre-edge values
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && in_valid && !in_stall) sb.note_param(in_param);
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_pos_x, out_pos_y, out_pos_z, out_dir_x, out_dir_y, out_dir_z);
    if (cycles > 400000) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver back-pressure: mostly open, short bursts of stall, rare long ones
  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_quiet) begin
      out_stall <= 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1;
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2: stall_left = $urandom_range(0, 3);
        3:       stall_left = $urandom_range(10, 70);
        default: stall_left = 0;
      endcase
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // cfg writes happen on the falling edge, captured at the next rising edge
  task automatic write_cfg(logic [2:0] idx, logic [59:0] val);
    @(negedge clk);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_wr_en <= 0;
  endtask

  task automatic set_curve(logic [59:0] a, logic [59:0] b, logic [59:0] c,
                           logic [59:0] d, logic [59:0] s, bit lp);
    write_cfg(CFG_POINT_A, a);
    write_cfg(CFG_POINT_B, b);
    write_cfg(CFG_POINT_C, c);
    write_cfg(CFG_POINT_D, d);
    write_cfg(CFG_SHIFT, s);
    write_cfg(CFG_LOOP_MODE, {59'd0, lp});
  endtask

  // one parameter transfer; caller is at a falling edge
  task automatic send_param(logic signed [23:0] prm, bit gaps);
    int idle;
    idle = 0;
    if (gaps) begin
      case ($urandom_range(0, 15))
        0, 1, 2: idle = $urandom_range(1, 3);
        3:       idle = $urandom_range(8, 40);
        default: idle = 0;
      endcase
    end
    if (idle > 0) begin
      in_valid <= 0;
      repeat (idle) @(negedge clk);
    end
    in_valid <= 1;
    in_param <= prm;
    do @(posedge clk); while (in_stall);
    sent++;
    @(negedge clk);
  endtask

  // drain: drop in_valid, wait for every expected result, then let the pipeline run empty
  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (PIPE_LAT + 8) @(negedge clk);
  endtask

  function automatic logic [59:0] rand_row();
    return 60'({$urandom(), $urandom()});
  endfunction

  // small coordinates, each within -4096..4095
  function automatic logic [59:0] mild_row();
    logic signed [19:0] c[3];
    foreach (c[k]) c[k] = $signed(20'($urandom_range(0, 8191))) - 20'sd4096;
    return {c[2], c[1], c[0]};
  endfunction

  function automatic logic signed [23:0] rand_param(bit lp);
    if (lp || $urandom_range(0, 9) == 0) return 24'($urandom());
    // clamped mode: mostly inside 0..1 with some spill on both ends
    return $signed(24'($urandom_range(0, 90000))) - 24'sd12000;
  endfunction

  localparam logic [59:0] ALL_MAX = {3{20'h7FFFF}};
  localparam logic [59:0] ALL_MIN = {3{20'h80000}};
  localparam logic signed [23:0] ONE = 24'sd65536;

  initial begin
    logic [59:0] same;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed, clamped: ends, midpoint, just short of the end, full range extremes
    set_curve(mild_row(), mild_row(), mild_row(), mild_row(), mild_row(), 0);
    send_param(24'sd0, 0);
    send_param(ONE, 0);
    send_param(ONE / 2, 0);
    send_param(ONE - 24'sd66, 0);
    send_param(ONE - 24'sd30, 0);
    send_param(-24'sd1, 0);
    send_param(24'sh7FFFFF, 0);
    send_param(24'sh800000, 0);
    drain();

    // directed, loop mode: negative params take the floor segment, wrap at the top
    write_cfg(CFG_LOOP_MODE, 60'd1);
    send_param(-24'sd1, 0);
    send_param(-ONE, 0);
    send_param(-ONE - 24'sd10, 0);
    send_param(24'sd3 * ONE + ONE - 24'sd5, 0);
    send_param(24'sh7FFFFF, 0);
    send_param(24'sh800000, 0);
    send_param(24'sh7FFFC0, 0);
    drain();

    // degenerate tangent: all points equal
    same = mild_row();
    set_curve(same, same, same, same, rand_row(), 1);
    send_param(24'sd12345, 0);
    send_param(-24'sd70000, 0);
    drain();
    // saturation at both extremes
    set_curve(ALL_MIN, ALL_MAX, ALL_MAX, ALL_MIN, ALL_MAX, 0);
    send_param(ONE / 2, 0);
    send_param(24'sd0, 0);
    drain();
    set_curve(ALL_MAX, ALL_MIN, ALL_MIN, ALL_MAX, ALL_MIN, 0);
    send_param(ONE / 2, 0);
    send_param(ONE - 24'sd100, 0);
    drain();

    // random phases over a spread of settings
    for (int ph = 0; ph < 10; ph++) begin
      bit lp;
      lp = ph[0];
      case (ph % 5)
        0: set_curve(ALL_MAX, ALL_MIN, ALL_MAX, ALL_MIN, ALL_MAX, lp);
        1: set_curve(rand_row(), rand_row(), rand_row(), rand_row(), rand_row(), lp);
        2: set_curve(mild_row(), mild_row(), mild_row(), mild_row(), mild_row(), lp);
        3: set_curve(ALL_MIN, ALL_MIN, ALL_MAX, ALL_MAX, ALL_MIN, lp);
        default: set_curve(mild_row(), rand_row(), mild_row(), rand_row(), '0, lp);
      endcase
      stall_quiet = (ph == 4);
      for (int n = 0; n < 160; n++) send_param(rand_param(lp), (ph % 3) != 2);
      drain();
      phases_run++;
    end

    stall_quiet = 1;
    drain();
    $display("covered %0d params over %0d random settings, %0d results checked",
             sent, phases_run, sb.checked);
    $display("clamped and looping curves, saturated and degenerate cases included");
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[files.f]
design/crc_pkg.sv
design/crc_curve.sv
design/crc_norm.sv
design/catmull_rom_curve_point_top.sv
dv/tb.sv
